>>> src/scf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scf_pkg: shared types and constants of the subtour component finder
// Payload structs, configuration register indexes and result kind codes.
// ----------------------------------------------------------------------------
package scf_pkg;

  localparam int MAX_NODES_DEF  = 32;
  localparam int NODE_IDX_W     = 5;   // row, col and node fields
  localparam int WEIGHT_W       = 16;
  localparam int NODE_COUNT_W   = 6;
  localparam int COMP_ID_W      = 4;
  localparam int COMP_CNT_W     = 5;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;
  localparam int CMD_FIFO_DEPTH = 2;

  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST     = 6'd32;
  localparam logic [WEIGHT_W-1:0]     EDGE_THRESHOLD_RST = 16'd0;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 1'd1;

  localparam logic KIND_MEMBER = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  typedef struct packed {
    logic [NODE_IDX_W-1:0] row;
    logic [NODE_IDX_W-1:0] col;
    logic [WEIGHT_W-1:0]   weight;
    logic                  last_entry;
  } in_item_t;

  typedef struct packed {
    logic                  kind;
    logic [COMP_ID_W-1:0]  component_id;
    logic [NODE_IDX_W-1:0] node;
    logic                  end_of_component;
    logic [COMP_CNT_W-1:0] component_total;
    logic                  last;
  } out_item_t;

  // Classified matrix entry handed from front to back.
  typedef struct packed {
    logic [NODE_IDX_W-1:0] row;
    logic [NODE_IDX_W-1:0] col;
    logic                  edge_bit;
    logic                  keep;
    logic                  last_entry;
  } cmd_t;

endpackage

>>> src/scf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scf_front: entry intake and classification
// Thresholds each matrix entry, range checks its indexes and queues the
// classified entry for the search engine.
// ----------------------------------------------------------------------------
module scf_front #(
  parameter int MAX_NODES = scf_pkg::MAX_NODES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [scf_pkg::WEIGHT_W-1:0]  edge_threshold_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  scf_pkg::in_item_t             in_data_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_pop_i,
  output scf_pkg::cmd_t                 cmd_o
);
  import scf_pkg::*;

  localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t             fifo_q [CMD_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  cmd_t             cls;

  always_comb begin
    cls.row        = in_data_i.row;
    cls.col        = in_data_i.col;
    cls.edge_bit   = (in_data_i.weight > edge_threshold_i);
    cls.keep       = (int'(in_data_i.row) < MAX_NODES) && (int'(in_data_i.col) < MAX_NODES);
    cls.last_entry = in_data_i.last_entry;
  end

  assign in_stall_o  = (count_q == CNT_W'(CMD_FIFO_DEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !cmd_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && cmd_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

endmodule

>>> src/scf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scf_back: edge store and breadth-first component search
// Writes classified entries into the edge bit matrix, runs the search on the
// final entry and streams members and the done item through an output reg.
// ----------------------------------------------------------------------------
module scf_back #(
  parameter int MAX_NODES = scf_pkg::MAX_NODES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [scf_pkg::NODE_COUNT_W-1:0] node_count_i,
  input  logic                             cmd_valid_i,
  output logic                             cmd_pop_o,
  input  scf_pkg::cmd_t                    cmd_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output scf_pkg::out_item_t               out_data_o
);
  import scf_pkg::*;

  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_SEEK    = 9'b000000010,
    ST_FETCH   = 9'b000000100,
    ST_ROW     = 9'b000001000,
    ST_LOAD    = 9'b000010000,
    ST_SCAN    = 9'b000100000,
    ST_EMIT_RD = 9'b001000000,
    ST_EMIT    = 9'b010000000,
    ST_DONE    = 9'b100000000
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         start_q, start_d;
  logic [CW-1:0]         head_q, head_d;
  logic [CW-1:0]         tail_q, tail_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [MAX_NODES-1:0]  visited_q, visited_d;
  logic [COMP_CNT_W-1:0] comp_cnt_q, comp_cnt_d;
  logic [MAX_NODES-1:0]  cand_q, cand_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  // edge bit matrix and visiting-order queue
  logic [MAX_NODES-1:0]  edge_mem [MAX_NODES];
  logic [MAX_NODES-1:0]  edge_rd_q;
  logic                  edge_we, edge_re;
  logic [NW-1:0]         node_mem [MAX_NODES];
  logic [NW-1:0]         qrd_q;
  logic                  q_we, q_re;
  logic [NW-1:0]         q_waddr, q_raddr, q_wdata;

  logic [CW-1:0]         n_cnt;
  logic [MAX_NODES-1:0]  nmask;
  logic [NW-1:0]         low_idx;
  logic                  out_free;
  logic                  eoc;

  // clamp node count into 2..MAX_NODES
  always_comb begin
    if (int'(node_count_i) < 2) begin
      n_cnt = CW'(2);
    end else if (int'(node_count_i) > MAX_NODES) begin
      n_cnt = CW'(MAX_NODES);
    end else begin
      n_cnt = CW'(node_count_i);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      nmask[i] = (i < int'(n_cnt));
    end
  end

  // lowest pending neighbor, which the model visits first
  always_comb begin
    low_idx = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (cand_q[i]) begin
        low_idx = NW'(i);
      end
    end
  end

  assign out_free  = !out_valid_q || !out_stall_i;
  assign eoc       = ((idx_q + 1'b1) == tail_q);
  assign cmd_pop_o = cmd_valid_i && (state_q == ST_IDLE);
  assign edge_we   = cmd_pop_o && cmd_i.keep;

  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    head_d      = head_q;
    tail_d      = tail_q;
    idx_d       = idx_q;
    visited_d   = visited_q;
    comp_cnt_d  = comp_cnt_q;
    cand_d      = cand_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    edge_re     = 1'b0;
    q_we        = 1'b0;
    q_re        = 1'b0;
    q_waddr     = tail_q[NW-1:0];
    q_wdata     = low_idx;
    q_raddr     = head_q[NW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o && cmd_i.last_entry) begin
          start_d    = '0;
          visited_d  = '0;
          comp_cnt_d = '0;
          state_d    = ST_SEEK;
        end
      end
      ST_SEEK: begin
        if (start_q >= n_cnt) begin
          state_d = ST_DONE;
        end else if (visited_q[start_q[NW-1:0]]) begin
          start_d = start_q + 1'b1;
        end else begin
          visited_d[start_q[NW-1:0]] = 1'b1;
          q_we    = 1'b1;
          q_waddr = '0;
          q_wdata = start_q[NW-1:0];
          head_d  = '0;
          tail_d  = CW'(1);
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (head_q == tail_q) begin
          // component complete; singletons and the full graph end the search
          if (tail_q == CW'(1) || tail_q == n_cnt) begin
            state_d = ST_DONE;
          end else begin
            idx_d   = '0;
            state_d = ST_EMIT_RD;
          end
        end else begin
          q_re    = 1'b1;
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        edge_re = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cand_d  = edge_rd_q & ~visited_q & nmask;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (cand_q == '0) begin
          head_d  = head_q + 1'b1;
          state_d = ST_FETCH;
        end else begin
          q_we               = 1'b1;
          tail_d             = tail_q + 1'b1;
          visited_d[low_idx] = 1'b1;
          cand_d[low_idx]    = 1'b0;
        end
      end
      ST_EMIT_RD: begin
        q_re    = 1'b1;
        q_raddr = idx_q[NW-1:0];
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_d.kind             = KIND_MEMBER;
          out_d.component_id     = comp_cnt_q[COMP_ID_W-1:0];
          out_d.node             = NODE_IDX_W'(qrd_q);
          out_d.end_of_component = eoc;
          out_d.component_total  = '0;
          out_d.last             = 1'b0;
          if (eoc) begin
            comp_cnt_d = comp_cnt_q + 1'b1;
            state_d    = ST_SEEK;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_EMIT_RD;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_d.kind             = KIND_DONE;
          out_d.component_id     = '0;
          out_d.node             = '0;
          out_d.end_of_component = 1'b0;
          out_d.component_total  = comp_cnt_q;
          out_d.last             = 1'b1;
          state_d                = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      idx_q       <= '0;
      visited_q   <= '0;
      comp_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      idx_q       <= idx_d;
      visited_q   <= visited_d;
      comp_cnt_q  <= comp_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[NW'(cmd_i.row)][NW'(cmd_i.col)] <= cmd_i.edge_bit;
    end
    if (edge_re) begin
      edge_rd_q <= edge_mem[qrd_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      node_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      qrd_q <= node_mem[q_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> src/subtour_component_finder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtour_component_finder_unit: connected component finder over a
// thresholded weight matrix
// Loads matrix entries, then emits breadth-first components and a done item.
// ----------------------------------------------------------------------------
// Matrix entries are taken one per cycle while the queue has room: a two-deep
// queue sits between the intake stage and the search engine, and the engine
// writes one edge bit per cycle while idle. The entry marked last_entry starts
// the search. While the search runs, up to two more entries are taken into the
// queue and wait there, and further entries stall. The search takes a seek
// step per start index tried; per node dequeued it fetches the node, reads its
// edge row, loads the unvisited neighbors and scans them, queueing each
// neighbor discovered; each member emitted takes a queue read and an output
// step, and a last step sends the done item. Output stalls add to this.
// Results leave through an output register, so the engine keeps searching
// while a result waits to be taken and holds only once its next result is
// ready.
module subtour_component_finder_unit #(
  parameter int MAX_NODES = scf_pkg::MAX_NODES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [scf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [scf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  scf_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output scf_pkg::out_item_t             out_data_o
);
  import scf_pkg::*;

  logic [NODE_COUNT_W-1:0] node_count_q;
  logic [WEIGHT_W-1:0]     edge_threshold_q;
  logic                    cmd_valid;
  logic                    cmd_pop;
  cmd_t                    cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q     <= NODE_COUNT_RST;
      edge_threshold_q <= EDGE_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NODE_COUNT:     node_count_q     <= cfg_data_i[NODE_COUNT_W-1:0];
        REG_EDGE_THRESHOLD: edge_threshold_q <= cfg_data_i[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  scf_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .edge_threshold_i(edge_threshold_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_data_i       (in_data_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_pop_i       (cmd_pop),
    .cmd_o           (cmd)
  );

  scf_back #(
    .MAX_NODES(MAX_NODES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .node_count_i(node_count_q),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for subtour_component_finder_unit
// Loads thresholded weight matrices and checks every breadth-first component
// member and done item against an in-bench graph search. Both handshakes
// see random idle cycles, and node count and threshold change between loads.
// ----------------------------------------------------------------------------
module tb;
  import scf_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 170;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned MAX_FULL_N     = 8;

  // Tracks the edge matrix and register copies; predicts the component
  // listing that each search produces and checks results in order.
  class component_tracker;
    localparam int unsigned MAX_REPORTS = 10;

    logic [MAX_NODES_DEF-1:0] edge_bits [MAX_NODES_DEF];
    logic [NODE_COUNT_W-1:0]  node_count;
    logic [WEIGHT_W-1:0]      threshold;
    out_item_t                expected_q [$];
    int unsigned              errors;

    function new();
      foreach (edge_bits[i]) edge_bits[i] = '0;
      node_count = NODE_COUNT_RST;
      threshold  = EDGE_THRESHOLD_RST;
      errors     = 0;
    endfunction

    function int unsigned searched_nodes();
      if (node_count < 2) return 2;
      if (node_count > MAX_NODES_DEF) return MAX_NODES_DEF;
      return node_count;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void add_expected(out_item_t r);
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_NODE_COUNT) node_count = data[NODE_COUNT_W-1:0];
      else if (idx == REG_EDGE_THRESHOLD) threshold = data[WEIGHT_W-1:0];
    endfunction

    function void note_entry(in_item_t it);
      edge_bits[it.row][it.col] = (it.weight > threshold);
      if (it.last_entry) find_components();
    endfunction

    function void find_components();
      int unsigned n, head, tail, comps, u;
      logic [MAX_NODES_DEF-1:0] seen;
      logic [NODE_IDX_W-1:0] order [MAX_NODES_DEF];
      out_item_t r;
      n     = searched_nodes();
      seen  = '0;
      comps = 0;
      for (int s = 0; s < n; s++) begin
        if (seen[s]) continue;
        head     = 0;
        tail     = 1;
        order[0] = NODE_IDX_W'(s);
        seen[s]  = 1'b1;
        while (head < tail) begin
          u = order[head];
          head++;
          for (int v = 0; v < n; v++) begin
            if (!seen[v] && edge_bits[u][v]) begin
              seen[v]     = 1'b1;
              order[tail] = NODE_IDX_W'(v);
              tail++;
            end
          end
        end
        // singleton or spanning component ends the search unreported
        if (tail == 1 || tail == n) break;
        for (int i = 0; i < tail; i++) begin
          r                  = '0;
          r.kind             = KIND_MEMBER;
          r.component_id     = COMP_ID_W'(comps);
          r.node             = order[i];
          r.end_of_component = (i == tail - 1);
          add_expected(r);
        end
        comps++;
      end
      r                 = '0;
      r.kind            = KIND_DONE;
      r.component_total = COMP_CNT_W'(comps);
      r.last            = 1'b1;
      add_expected(r);
    endfunction

    function string show(out_item_t o);
      return $sformatf("kind=%0d id=%0d node=%0d eoc=%0d total=%0d last=%0d", o.kind,
                       o.component_id, o.node, o.end_of_component, o.component_total,
                       o.last);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("unexpected result: %s", show(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.component_id !== want.component_id ||
          got.node !== want.node || got.end_of_component !== want.end_of_component ||
          got.component_total !== want.component_total || got.last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result mismatch: expected %s, got %s", show(want), show(got));
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  out_item_t             out_data;

  component_tracker sb;
  bit               in_idle_on  = 1'b1;
  bit               out_idle_on = 1'b1;
  int unsigned      items_sent  = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      node_group [MAX_NODES_DEF];

  subtour_component_finder_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result sink with random stall before each transfer
  initial begin : result_sink
    int unsigned hold;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = out_idle_on ? $urandom_range(0, 8) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_data);
    end
  end

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_entry(input int unsigned r, input int unsigned c,
                            input logic [WEIGHT_W-1:0] w, input bit last_one);
    in_item_t    it;
    int unsigned gap;
    it.row        = NODE_IDX_W'(r);
    it.col        = NODE_IDX_W'(c);
    it.weight     = w;
    it.last_entry = last_one;
    gap = in_idle_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_entry(it);
    items_sent++;
  endtask

  // block is idle once all results are in and queued entries have drained
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [WEIGHT_W-1:0] weight_for(input bit is_edge);
    logic [WEIGHT_W-1:0] t;
    t = sb.threshold;
    if (is_edge && t != 16'hFFFF) begin
      if ($urandom_range(0, 7) == 0) return t + 16'd1;
      return 16'($urandom_range(65535, int'(t) + 1));
    end
    if ($urandom_range(0, 7) == 0) return t;
    return 16'($urandom_range(int'(t), 0));
  endfunction

  function automatic bit edge_between(input int unsigned r, input int unsigned c);
    if (node_group[r] == node_group[c]) return $urandom_range(0, 3) != 0;
    return $urandom_range(0, 19) == 0;
  endfunction

  function automatic void assign_groups(input int unsigned n);
    int unsigned ng;
    ng = (n / 2 > 1) ? $urandom_range(1, n / 2) : 1;
    foreach (node_group[i]) node_group[i] = $urandom_range(0, ng - 1);
  endfunction

  // every n-by-n entry (n up to MAX_FULL_N), row order or shuffled, with
  // stray entries outside n, an occasional threshold change midway, and now
  // and then cut short
  task automatic full_load(input int unsigned n);
    int          cells [MAX_FULL_N * MAX_FULL_N];
    int          j, k, tmp;
    int unsigned cut, stop_at;
    for (int i = 0; i < n * n; i++) cells[i] = i;
    if ($urandom_range(0, 1) != 0) begin
      for (k = n * n - 1; k > 0; k--) begin
        j        = $urandom_range(0, k);
        tmp      = cells[k];
        cells[k] = cells[j];
        cells[j] = tmp;
      end
    end
    cut     = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n * n - 1) : n * n;
    stop_at = ($urandom_range(0, 9) == 0) ? (n * n) / 2 : n * n;
    for (k = 0; k < stop_at; k++) begin
      if (k == cut) begin
        drain();
        write_cfg(REG_EDGE_THRESHOLD, 16'($urandom_range(0, 65535)));
      end
      if (n < MAX_NODES_DEF && $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) != 0)
          send_entry($urandom_range(n, 31), $urandom_range(0, 31),
                     16'($urandom_range(0, 65535)), 1'b0);
        else
          send_entry($urandom_range(0, 31), $urandom_range(n, 31),
                     16'($urandom_range(0, 65535)), 1'b0);
      end
      send_entry(cells[k] / n, cells[k] % n,
                 weight_for(edge_between(cells[k] / n, cells[k] % n)),
                 k == n * n - 1);
    end
  endtask

  task automatic partial_load(input int unsigned n, input int unsigned cnt);
    int unsigned r, c;
    for (int k = 0; k < cnt; k++) begin
      r = $urandom_range(0, n - 1);
      c = $urandom_range(0, n - 1);
      send_entry(r, c, weight_for(edge_between(r, c)), k == cnt - 1);
    end
  endtask

  // arbitrary indices and weights; sometimes no search at the end
  task automatic noise_load(input int unsigned cnt);
    bit finish_search;
    finish_search = $urandom_range(0, 3) != 0;
    for (int k = 0; k < cnt; k++)
      send_entry($urandom_range(0, 31), $urandom_range(0, 31),
                 16'($urandom_range(0, 65535)), finish_search && k == cnt - 1);
  endtask

  initial begin : stimulus
    int unsigned         n, base;
    logic [WEIGHT_W-1:0] w;
    bit                  is_edge;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    drain();

    // two nodes, zero threshold: weight 0 is no edge, spanning pair stops search
    write_cfg(REG_NODE_COUNT, 16'd0);
    write_cfg(REG_EDGE_THRESHOLD, 16'd0);
    send_entry(0, 0, 16'h0000, 1'b0);
    send_entry(0, 1, 16'hFFFF, 1'b0);
    send_entry(1, 0, 16'h0000, 1'b0);
    send_entry(31, 31, 16'hFFFF, 1'b0);
    send_entry(1, 1, 16'h0000, 1'b1);

    // full-scale threshold: nothing exceeds it, node 0 alone stops the search
    drain();
    write_cfg(REG_NODE_COUNT, 16'd3);
    write_cfg(REG_EDGE_THRESHOLD, 16'hFFFF);
    send_entry(0, 2, 16'hFFFF, 1'b0);
    send_entry(1, 2, 16'hFFFF, 1'b0);
    send_entry(2, 0, 16'h0000, 1'b0);
    send_entry(2, 1, 16'hFFFF, 1'b0);
    send_entry(0, 1, 16'hFFFF, 1'b0);
    send_entry(2, 2, 16'hFFFF, 1'b1);

    // weight equal to threshold is no edge; two pairs emitted
    drain();
    write_cfg(REG_NODE_COUNT, 16'd4);
    write_cfg(REG_EDGE_THRESHOLD, 16'h8000);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        w = 16'h8000;
        if (r == 0 && c == 1) w = 16'h8001;
        if (r == 2 && c == 3) w = 16'hFFFF;
        send_entry(r, c, w, r == 3 && c == 3);
      end
    end

    // node count above the limit: all 32 columns of row 0 are searched and
    // node 0 with at most a self loop stops the search
    drain();
    in_idle_on  = $urandom_range(0, 1);
    out_idle_on = $urandom_range(0, 1);
    write_cfg(REG_NODE_COUNT, 16'd63);
    write_cfg(REG_EDGE_THRESHOLD, 16'($urandom_range(0, 65534)));
    for (int c = 0; c < MAX_NODES_DEF; c++) begin
      is_edge = (c == 0) && ($urandom_range(0, 1) != 0);
      send_entry(0, c, weight_for(is_edge), c == MAX_NODES_DEF - 1);
    end

    // full 8-node matrix, four two-node components
    drain();
    write_cfg(REG_NODE_COUNT, 16'(MAX_FULL_N));
    write_cfg(REG_EDGE_THRESHOLD, 16'($urandom_range(0, 65534)));
    for (int r = 0; r < MAX_FULL_N; r++) begin
      for (int c = 0; c < MAX_FULL_N; c++) begin
        is_edge = (r / 2 == c / 2 && r != c) || (r == c && $urandom_range(0, 1) != 0);
        send_entry(r, c, weight_for(is_edge),
                   r == MAX_FULL_N - 1 && c == MAX_FULL_N - 1);
      end
    end

    // searches stay inside the fully loaded 8-by-8 corner
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      in_idle_on  = $urandom_range(0, 3) != 0;
      out_idle_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 3) != 0) begin
        drain();
        case ($urandom_range(0, 9))
          0:       write_cfg(REG_NODE_COUNT, 16'd0);
          1:       write_cfg(REG_NODE_COUNT, 16'd1);
          2:       write_cfg(REG_NODE_COUNT, 16'(MAX_FULL_N));
          default: write_cfg(REG_NODE_COUNT, 16'($urandom_range(2, MAX_FULL_N)));
        endcase
        case ($urandom_range(0, 7))
          0:       write_cfg(REG_EDGE_THRESHOLD, 16'h0000);
          1:       write_cfg(REG_EDGE_THRESHOLD, 16'hFFFF);
          default: write_cfg(REG_EDGE_THRESHOLD, 16'($urandom_range(0, 65535)));
        endcase
      end
      n = sb.searched_nodes();
      assign_groups(n);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if (n <= MAX_FULL_N) full_load(n);
          else partial_load(n, $urandom_range(1, 16));
        end
        4, 5, 6, 7: partial_load(n, $urandom_range(1, 12));
        default:    noise_load($urandom_range(1, 10));
      endcase
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
